[rtl/core/rau_pkg.sv]
package rau_pkg;

    // operation codes
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_LT  = 4'd4;
    localparam logic [3:0] OP_GT  = 4'd5;
    localparam logic [3:0] OP_LE  = 4'd6;
    localparam logic [3:0] OP_GE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;
    localparam logic [3:0] OP_NEG = 4'd10;
    localparam logic [3:0] OP_POW = 4'd11;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // iteration counts of the serial units
    localparam logic [7:0] MUL_STEPS = 8'd64;
    localparam logic [7:0] DIV_STEPS = 8'd128;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_SET_AZ,
        UOP_SET_BZ,
        UOP_GCD_A,
        UOP_GCD_B,
        UOP_GCD_F,
        UOP_DIV_AN,
        UOP_DIV_AD,
        UOP_DIV_BN,
        UOP_DIV_BD,
        UOP_DIV_FN,
        UOP_DIV_FD,
        UOP_MUL_X,
        UOP_MUL_Y,
        UOP_MUL_DEN,
        UOP_MUL_MN,
        UOP_MUL_DN,
        UOP_MUL_DD,
        UOP_MUL_PN,
        UOP_MUL_PD,
        UOP_COMBINE,
        UOP_NEG,
        UOP_POW_INIT,
        UOP_POW_SET
    } t_uop;

    typedef enum logic [2:0] {
        RK_ZERO,
        RK_ONE,
        RK_DIVZ,
        RK_OVF,
        RK_CMP,
        RK_EQ,
        RK_FIN
    } t_res_kind;

    typedef enum logic [1:0] {
        GP_SH,
        GP_AEV,
        GP_LOOP,
        GP_LSH
    } t_gcd_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_AZ,
        S_GCD_A,
        S_DIV_AN,
        S_DIV_AD,
        S_CHK_B,
        S_BZ,
        S_GCD_B,
        S_DIV_BN,
        S_DIV_BD,
        S_DISPATCH,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_DEN,
        S_COMBINE,
        S_MUL_MN,
        S_MUL_DN,
        S_MUL_DD,
        S_NEG,
        S_POW_INIT,
        S_POW_N,
        S_POW_D,
        S_POW_SET,
        S_FIN_CHK,
        S_GCD_F,
        S_DIV_FN,
        S_DIV_FD,
        S_RES
    } t_state;

    typedef struct packed {
        logic      load;
        logic      go;
        t_uop      uop;
        logic      res_we;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic       done;
        logic [3:0] op;
        logic       ad_zero;
        logic       bd_zero;
        logic       am_zero;
        logic       bm_zero;
        logic       num_zero;
        logic       negexp;
        logic       k_zero;
        logic       pcnt_zero;
        logic       mul_hi_nz;
    } t_dp_status;

endpackage

[rtl/core/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, sub, mul, div, neg and integer power of
// signed rationals, and the six relations, all on reduced fractions.
//
// Command channel: drive i_op and the operand ports, raise start; the
// transaction is taken at the edge where start is high and busy is low.
// Operands are captured at that edge and may change afterwards.
// Result channel: o_valid is high for exactly one cycle with o_res_num,
// o_res_den, o_compare_true and o_status; the receiver cannot stall it,
// so it must take the result in that cycle. busy drops in the same cycle
// and a new command may be taken there.
//
// One transaction at a time. Each step runs on a shared serial unit: a
// shift-add multiplier, a restoring divider and a binary gcd that takes
// one shift or subtract per cycle. Pow repeats a numerator and a
// denominator multiply for each unit of exponent magnitude. Errors found
// up front return straight from the check state without a serial step.
// Reset (synchronous, active low) returns the controller to idle and drops
// any transaction in flight; no result is shown for it.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_op,
    input  logic signed [63:0] i_a_num,
    input  logic [62:0]        i_a_den,
    input  logic signed [63:0] i_b_num,
    input  logic [62:0]        i_b_den,
    input  logic signed [6:0]  i_exponent,
    output logic               o_valid,
    output logic signed [63:0] o_res_num,
    output logic [62:0]        o_res_den,
    output logic               o_compare_true,
    output logic [1:0]         o_status
);
    import rau_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    rau_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    rau_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_dp_status    (dp_status),
        .i_op           (i_op),
        .i_a_num        (i_a_num),
        .i_a_den        (i_a_den),
        .i_b_num        (i_b_num),
        .i_b_den        (i_b_den),
        .i_exponent     (i_exponent),
        .o_res_num      (o_res_num),
        .o_res_den      (o_res_den),
        .o_compare_true (o_compare_true),
        .o_status       (o_status),
        .o_valid        (o_valid)
    );

endmodule

[rtl/core/rau_datapath.sv]
module rau_datapath #(
    parameter int WORD_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_dp_cmd    i_cmd,
    output rau_pkg::t_dp_status o_dp_status,
    input  logic [3:0]          i_op,
    input  logic signed [63:0]  i_a_num,
    input  logic [62:0]         i_a_den,
    input  logic signed [63:0]  i_b_num,
    input  logic [62:0]         i_b_den,
    input  logic signed [6:0]   i_exponent,
    output logic signed [63:0]  o_res_num,
    output logic [62:0]         o_res_den,
    output logic                o_compare_true,
    output logic [1:0]          o_status,
    output logic                o_valid
);
    import rau_pkg::*;

    localparam logic [127:0] LIM = (128'd1 << (WORD_BITS - 1)) - 128'd1;

    // operand and working registers
    logic [3:0]   r_op, n_op;
    logic         r_an, n_an, r_bn, n_bn, r_sign, n_sign;
    logic [63:0]  r_am, n_am, r_ad, n_ad, r_bm, n_bm, r_bd, n_bd;
    logic [6:0]   r_e, n_e;
    logic [127:0] r_x, n_x, r_y, n_y, r_num, n_num, r_den, n_den;
    logic [63:0]  r_pn, n_pn, r_pd, n_pd;
    logic [6:0]   r_pcnt, n_pcnt;

    // serial unit registers
    logic         r_active, n_active;
    t_uop         r_uop, n_uop;
    logic [127:0] r_ga, n_ga, r_gb, n_gb;
    logic [6:0]   r_sh, n_sh;
    t_gcd_phase   r_gph, n_gph;
    logic [127:0] r_rem, n_rem, r_dn, n_dn;
    logic [63:0]  r_mcand, n_mcand;
    logic [127:0] r_prod, n_prod;
    logic [7:0]   r_icnt, n_icnt;

    // result registers
    logic [63:0]  r_res_num, n_res_num;
    logic [62:0]  r_res_den, n_res_den;
    logic         r_cmp, n_cmp, r_valid, n_valid;
    logic [1:0]   r_st, n_st;

    logic [6:0]   k;
    logic         start_now, done, is_gcd, is_div, is_mul;
    logic [63:0]  a_mag, b_mag;
    logic [64:0]  mul_sum;
    logic [128:0] div_rs, div_diff;
    logic         div_ge;
    logic [127:0] cap;
    logic         x_lt_y, x_gt_y, lt, gt, eq;

    assign k = r_e[6] ? (7'd0 - r_e) : r_e;
    assign start_now = i_cmd.go && !r_active;
    assign a_mag = i_a_num[63] ? (64'd0 - i_a_num) : i_a_num;
    assign b_mag = i_b_num[63] ? (64'd0 - i_b_num) : i_b_num;

    // classify the running micro-op
    always_comb begin
        is_gcd = 1'b0;
        is_div = 1'b0;
        is_mul = 1'b0;
        case (r_uop)
            UOP_GCD_A, UOP_GCD_B, UOP_GCD_F: is_gcd = 1'b1;
            UOP_DIV_AN, UOP_DIV_AD, UOP_DIV_BN, UOP_DIV_BD,
            UOP_DIV_FN, UOP_DIV_FD: is_div = 1'b1;
            UOP_MUL_X, UOP_MUL_Y, UOP_MUL_DEN, UOP_MUL_MN, UOP_MUL_DN,
            UOP_MUL_DD, UOP_MUL_PN, UOP_MUL_PD: is_mul = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        if (is_gcd) begin
            done = r_active && (r_gph == GP_LSH) && (r_sh == 7'd0);
        end else if (is_div || is_mul) begin
            done = r_active && (r_icnt == 8'd0);
        end else begin
            done = r_active;
        end
    end

    // one step of each serial unit
    assign mul_sum  = {1'b0, r_prod[127:64]} + (r_prod[0] ? {1'b0, r_mcand} : 65'd0);
    assign div_rs   = {r_rem, r_dn[127]};
    assign div_diff = div_rs - {1'b0, r_ga};
    assign div_ge   = div_rs >= {1'b0, r_ga};

    // relations from cross products
    assign x_lt_y = r_x < r_y;
    assign x_gt_y = r_x > r_y;
    assign lt = (r_an != r_bn) ? r_an : (r_an ? x_gt_y : x_lt_y);
    assign gt = (r_an != r_bn) ? r_bn : (r_an ? x_lt_y : x_gt_y);
    assign eq = (r_an == r_bn) && (r_am == r_bm) && (r_ad == r_bd);
    assign cap = LIM + {127'd0, r_sign};

    always_comb begin
        n_op = r_op; n_an = r_an; n_bn = r_bn; n_sign = r_sign;
        n_am = r_am; n_ad = r_ad; n_bm = r_bm; n_bd = r_bd; n_e = r_e;
        n_x = r_x; n_y = r_y; n_num = r_num; n_den = r_den;
        n_pn = r_pn; n_pd = r_pd; n_pcnt = r_pcnt;
        n_active = r_active; n_uop = r_uop;
        n_ga = r_ga; n_gb = r_gb; n_sh = r_sh; n_gph = r_gph;
        n_rem = r_rem; n_dn = r_dn; n_mcand = r_mcand; n_prod = r_prod;
        n_icnt = r_icnt;

        // capture a new transaction
        if (i_cmd.load) begin
            n_op = i_op;
            n_an = i_a_num[63];
            n_bn = i_b_num[63];
            n_am = a_mag;
            n_bm = b_mag;
            n_ad = {1'b0, i_a_den};
            n_bd = {1'b0, i_b_den};
            n_e  = i_exponent;
        end

        if (start_now) begin
            // launch a micro-op
            n_active = 1'b1;
            n_uop    = i_cmd.uop;
            case (i_cmd.uop)
                UOP_SET_AZ: n_ad = 64'd1;
                UOP_SET_BZ: n_bd = 64'd1;
                UOP_GCD_A: begin
                    n_ga = {64'd0, r_am}; n_gb = {64'd0, r_ad};
                    n_sh = 7'd0; n_gph = GP_SH;
                end
                UOP_GCD_B: begin
                    n_ga = {64'd0, r_bm}; n_gb = {64'd0, r_bd};
                    n_sh = 7'd0; n_gph = GP_SH;
                end
                UOP_GCD_F: begin
                    n_ga = r_num; n_gb = r_den;
                    n_sh = 7'd0; n_gph = GP_SH;
                end
                UOP_DIV_AN: begin n_dn = {64'd0, r_am}; n_rem = '0; n_icnt = DIV_STEPS; end
                UOP_DIV_AD: begin n_dn = {64'd0, r_ad}; n_rem = '0; n_icnt = DIV_STEPS; end
                UOP_DIV_BN: begin n_dn = {64'd0, r_bm}; n_rem = '0; n_icnt = DIV_STEPS; end
                UOP_DIV_BD: begin n_dn = {64'd0, r_bd}; n_rem = '0; n_icnt = DIV_STEPS; end
                UOP_DIV_FN: begin n_dn = r_num; n_rem = '0; n_icnt = DIV_STEPS; end
                UOP_DIV_FD: begin n_dn = r_den; n_rem = '0; n_icnt = DIV_STEPS; end
                UOP_MUL_X: begin
                    n_mcand = r_am; n_prod = {64'd0, r_bd}; n_icnt = MUL_STEPS;
                end
                UOP_MUL_Y: begin
                    n_mcand = r_bm; n_prod = {64'd0, r_ad}; n_icnt = MUL_STEPS;
                end
                UOP_MUL_DEN: begin
                    n_mcand = r_ad; n_prod = {64'd0, r_bd}; n_icnt = MUL_STEPS;
                end
                UOP_MUL_MN: begin
                    n_mcand = r_am; n_prod = {64'd0, r_bm}; n_icnt = MUL_STEPS;
                    n_sign = r_an ^ r_bn;
                end
                UOP_MUL_DN: begin
                    n_mcand = r_am; n_prod = {64'd0, r_bd}; n_icnt = MUL_STEPS;
                    n_sign = r_an ^ r_bn;
                end
                UOP_MUL_DD: begin
                    n_mcand = r_ad; n_prod = {64'd0, r_bm}; n_icnt = MUL_STEPS;
                end
                UOP_MUL_PN: begin
                    n_mcand = r_pn; n_prod = {64'd0, r_am}; n_icnt = MUL_STEPS;
                end
                UOP_MUL_PD: begin
                    n_mcand = r_pd; n_prod = {64'd0, r_ad}; n_icnt = MUL_STEPS;
                    n_pcnt = r_pcnt - 7'd1;
                end
                UOP_COMBINE: begin
                    if (r_an == ((r_op == OP_SUB) ? !r_bn : r_bn)) begin
                        n_num = r_x + r_y; n_sign = r_an;
                    end else if (!x_lt_y) begin
                        n_num = r_x - r_y; n_sign = r_an;
                    end else begin
                        n_num = r_y - r_x; n_sign = (r_op == OP_SUB) ? !r_bn : r_bn;
                    end
                end
                UOP_NEG: begin
                    n_num = {64'd0, r_am}; n_den = {64'd0, r_ad}; n_sign = !r_an;
                end
                UOP_POW_INIT: begin
                    n_pn = 64'd1; n_pd = 64'd1; n_pcnt = k;
                end
                UOP_POW_SET: begin
                    n_sign = r_an && k[0];
                    if (r_e[6]) begin
                        n_num = {64'd0, r_pd}; n_den = {64'd0, r_pn};
                    end else begin
                        n_num = {64'd0, r_pn}; n_den = {64'd0, r_pd};
                    end
                end
                default: ;
            endcase
        end else if (done) begin
            // retire the micro-op and write its destination
            n_active = 1'b0;
            case (r_uop)
                UOP_DIV_AN: n_am = r_dn[63:0];
                UOP_DIV_AD: n_ad = r_dn[63:0];
                UOP_DIV_BN: n_bm = r_dn[63:0];
                UOP_DIV_BD: n_bd = r_dn[63:0];
                UOP_DIV_FN: n_num = r_dn;
                UOP_DIV_FD: n_den = r_dn;
                UOP_MUL_X: n_x = r_prod;
                UOP_MUL_Y: n_y = r_prod;
                UOP_MUL_DEN, UOP_MUL_DD: n_den = r_prod;
                UOP_MUL_MN, UOP_MUL_DN: n_num = r_prod;
                UOP_MUL_PN: n_pn = r_prod[63:0];
                UOP_MUL_PD: n_pd = r_prod[63:0];
                default: ;
            endcase
        end else if (r_active) begin
            // advance the serial unit one step
            if (is_mul) begin
                n_prod = {mul_sum, r_prod[63:1]};
                n_icnt = r_icnt - 8'd1;
            end else if (is_div) begin
                n_rem  = div_ge ? div_diff[127:0] : div_rs[127:0];
                n_dn   = {r_dn[126:0], div_ge};
                n_icnt = r_icnt - 8'd1;
            end else if (is_gcd) begin
                case (r_gph)
                    GP_SH: begin
                        if (r_ga == '0) begin
                            n_ga = r_gb; n_gph = GP_LSH;
                        end else if (r_gb == '0) begin
                            n_gph = GP_LSH;
                        end else if (!r_ga[0] && !r_gb[0]) begin
                            n_ga = r_ga >> 1; n_gb = r_gb >> 1; n_sh = r_sh + 7'd1;
                        end else begin
                            n_gph = GP_AEV;
                        end
                    end
                    GP_AEV: begin
                        if (!r_ga[0]) n_ga = r_ga >> 1;
                        else n_gph = GP_LOOP;
                    end
                    GP_LOOP: begin
                        if (r_gb == '0) begin
                            n_gph = GP_LSH;
                        end else if (!r_gb[0]) begin
                            n_gb = r_gb >> 1;
                        end else if (r_ga > r_gb) begin
                            n_ga = r_gb; n_gb = r_ga - r_gb;
                        end else begin
                            n_gb = r_gb - r_ga;
                        end
                    end
                    GP_LSH: begin
                        n_ga = r_ga << 1; n_sh = r_sh - 7'd1;
                    end
                    default: n_gph = GP_SH;
                endcase
            end
        end
    end

    // form the result transaction
    always_comb begin
        n_valid   = 1'b0;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_cmp     = r_cmp;
        n_st      = r_st;
        if (i_cmd.res_we) begin
            n_valid   = 1'b1;
            n_res_num = 64'd0;
            n_res_den = 63'd1;
            n_cmp     = 1'b0;
            n_st      = ST_OK;
            case (i_cmd.res_kind)
                RK_ZERO: ;
                RK_ONE:  n_res_num = 64'd1;
                RK_DIVZ: n_st = ST_DIVZ;
                RK_OVF:  n_st = ST_OVF;
                RK_CMP: begin
                    case (r_op)
                        OP_LT:   n_cmp = lt;
                        OP_GT:   n_cmp = gt;
                        OP_LE:   n_cmp = !gt;
                        default: n_cmp = !lt;
                    endcase
                end
                RK_EQ: n_cmp = (r_op == OP_EQ) == eq;
                RK_FIN: begin
                    if (r_num > cap || r_den > LIM) begin
                        n_st = ST_OVF;
                    end else begin
                        n_res_num = r_sign ? (64'd0 - r_num[63:0]) : r_num[63:0];
                        n_res_den = r_den[62:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_uop    <= UOP_NONE;
        end else begin
            r_active <= n_active;
            r_valid  <= n_valid;
            r_uop    <= n_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_an <= n_an; r_bn <= n_bn; r_sign <= n_sign;
        r_am <= n_am; r_ad <= n_ad; r_bm <= n_bm; r_bd <= n_bd; r_e <= n_e;
        r_x <= n_x; r_y <= n_y; r_num <= n_num; r_den <= n_den;
        r_pn <= n_pn; r_pd <= n_pd; r_pcnt <= n_pcnt;
        r_ga <= n_ga; r_gb <= n_gb; r_sh <= n_sh; r_gph <= n_gph;
        r_rem <= n_rem; r_dn <= n_dn; r_mcand <= n_mcand; r_prod <= n_prod;
        r_icnt <= n_icnt;
        r_res_num <= n_res_num; r_res_den <= n_res_den;
        r_cmp <= n_cmp; r_st <= n_st;
    end

    // status toward the controller
    assign o_dp_status.done      = done;
    assign o_dp_status.op        = r_op;
    assign o_dp_status.ad_zero   = (r_ad == 64'd0);
    assign o_dp_status.bd_zero   = (r_bd == 64'd0);
    assign o_dp_status.am_zero   = (r_am == 64'd0);
    assign o_dp_status.bm_zero   = (r_bm == 64'd0);
    assign o_dp_status.num_zero  = (r_num == '0);
    assign o_dp_status.negexp    = r_e[6];
    assign o_dp_status.k_zero    = (k == 7'd0);
    assign o_dp_status.pcnt_zero = (r_pcnt == 7'd0);
    assign o_dp_status.mul_hi_nz = |r_prod[127:64];

    assign o_res_num      = r_res_num;
    assign o_res_den      = r_res_den;
    assign o_compare_true = r_cmp;
    assign o_status       = r_st;
    assign o_valid        = r_valid;

endmodule

[rtl/core/rau_controller.sv]
module rau_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  rau_pkg::t_dp_status i_status,
    output rau_pkg::t_dp_cmd    o_cmd
);
    import rau_pkg::*;

    t_state    r_state, n_state;
    t_res_kind r_rk, n_rk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rk    <= RK_ZERO;
        end else begin
            r_state <= n_state;
            r_rk    <= n_rk;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_rk    = r_rk;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            // screen op code and zero denominators
            S_CHECK: begin
                if (i_status.op > OP_POW) begin
                    n_rk = RK_ZERO; n_state = S_RES;
                end else if (i_status.ad_zero || (i_status.op <= OP_NE && i_status.bd_zero)) begin
                    n_rk = RK_DIVZ; n_state = S_RES;
                end else if (i_status.am_zero) begin
                    n_state = S_AZ;
                end else begin
                    n_state = S_GCD_A;
                end
            end
            S_AZ: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_SET_AZ;
                if (i_status.done) n_state = S_CHK_B;
            end
            S_GCD_A: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_GCD_A;
                if (i_status.done) n_state = S_DIV_AN;
            end
            S_DIV_AN: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_DIV_AN;
                if (i_status.done) n_state = S_DIV_AD;
            end
            S_DIV_AD: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_DIV_AD;
                if (i_status.done) n_state = S_CHK_B;
            end
            S_CHK_B: begin
                if (i_status.op > OP_NE) n_state = S_DISPATCH;
                else if (i_status.bm_zero) n_state = S_BZ;
                else n_state = S_GCD_B;
            end
            S_BZ: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_SET_BZ;
                if (i_status.done) n_state = S_DISPATCH;
            end
            S_GCD_B: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_GCD_B;
                if (i_status.done) n_state = S_DIV_BN;
            end
            S_DIV_BN: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_DIV_BN;
                if (i_status.done) n_state = S_DIV_BD;
            end
            S_DIV_BD: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_DIV_BD;
                if (i_status.done) n_state = S_DISPATCH;
            end
            // branch on the operation
            S_DISPATCH: begin
                case (i_status.op)
                    OP_ADD, OP_SUB, OP_LT, OP_GT, OP_LE, OP_GE: n_state = S_MUL_X;
                    OP_MUL: n_state = S_MUL_MN;
                    OP_DIV: begin
                        if (i_status.bm_zero) begin
                            n_rk = RK_DIVZ; n_state = S_RES;
                        end else begin
                            n_state = S_MUL_DN;
                        end
                    end
                    OP_EQ, OP_NE: begin
                        n_rk = RK_EQ; n_state = S_RES;
                    end
                    OP_NEG: n_state = S_NEG;
                    default: begin
                        if (i_status.negexp && i_status.am_zero) begin
                            n_rk = RK_DIVZ; n_state = S_RES;
                        end else if (i_status.k_zero) begin
                            n_rk = RK_ONE; n_state = S_RES;
                        end else if (i_status.am_zero) begin
                            n_rk = RK_ZERO; n_state = S_RES;
                        end else begin
                            n_state = S_POW_INIT;
                        end
                    end
                endcase
            end
            S_MUL_X: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_X;
                if (i_status.done) n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_Y;
                if (i_status.done) begin
                    if (i_status.op > OP_SUB) begin
                        n_rk = RK_CMP; n_state = S_RES;
                    end else begin
                        n_state = S_MUL_DEN;
                    end
                end
            end
            S_MUL_DEN: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_DEN;
                if (i_status.done) begin
                    n_state = (i_status.op == OP_MUL) ? S_FIN_CHK : S_COMBINE;
                end
            end
            S_COMBINE: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_COMBINE;
                if (i_status.done) n_state = S_FIN_CHK;
            end
            S_MUL_MN: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_MN;
                if (i_status.done) n_state = S_MUL_DEN;
            end
            S_MUL_DN: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_DN;
                if (i_status.done) n_state = S_MUL_DD;
            end
            S_MUL_DD: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_DD;
                if (i_status.done) n_state = S_FIN_CHK;
            end
            S_NEG: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_NEG;
                if (i_status.done) n_state = S_FIN_CHK;
            end
            S_POW_INIT: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_POW_INIT;
                if (i_status.done) n_state = S_POW_N;
            end
            // drop out as soon as a power leaves the word
            S_POW_N: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_PN;
                if (i_status.done) begin
                    if (i_status.mul_hi_nz) begin
                        n_rk = RK_OVF; n_state = S_RES;
                    end else begin
                        n_state = S_POW_D;
                    end
                end
            end
            S_POW_D: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_MUL_PD;
                if (i_status.done) begin
                    if (i_status.mul_hi_nz) begin
                        n_rk = RK_OVF; n_state = S_RES;
                    end else if (i_status.pcnt_zero) begin
                        n_state = S_POW_SET;
                    end else begin
                        n_state = S_POW_N;
                    end
                end
            end
            S_POW_SET: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_POW_SET;
                if (i_status.done) n_state = S_FIN_CHK;
            end
            // reduce the final fraction
            S_FIN_CHK: begin
                if (i_status.num_zero) begin
                    n_rk = RK_ZERO; n_state = S_RES;
                end else begin
                    n_state = S_GCD_F;
                end
            end
            S_GCD_F: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_GCD_F;
                if (i_status.done) n_state = S_DIV_FN;
            end
            S_DIV_FN: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_DIV_FN;
                if (i_status.done) n_state = S_DIV_FD;
            end
            S_DIV_FD: begin
                o_cmd.go = 1'b1; o_cmd.uop = UOP_DIV_FD;
                if (i_status.done) begin
                    n_rk = RK_FIN; n_state = S_RES;
                end
            end
            S_RES: begin
                o_cmd.res_we   = 1'b1;
                o_cmd.res_kind = r_rk;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/core/rau_checker.sv]
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [63:0] o_res_num,
    input logic [62:0] o_res_den,
    input logic        o_compare_true,
    input logic [1:0]  o_status
);
    import rau_pkg::*;

    // an accepted transaction keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // every completed transaction shows exactly one result
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // results are single-cycle strobes
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // an error result carries the neutral value
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_res_num == 64'd0 && o_res_den == 63'd1 && !o_compare_true))
        else $error("error result carries a value");

    // a result has a legal status and a nonzero denominator
    a_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res_den != 63'd0 &&
        (o_status == ST_OK || o_status == ST_DIVZ || o_status == ST_OVF)))
        else $error("illegal result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_res_num      (o_res_num),
    .o_res_den      (o_res_den),
    .o_compare_true (o_compare_true),
    .o_status       (o_status)
);
